// File: hw/rtl/mips_subset_instruction_executor_unit_macros.svh
// Assertion macros for the MIPS subset executor.
`ifndef MIPS_SUBSET_INSTRUCTION_EXECUTOR_UNIT_MACROS_SVH
`define MIPS_SUBSET_INSTRUCTION_EXECUTOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MSIE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("msie assertion failed");
`define MSIE_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("msie assertion failed");
`else
`define MSIE_ASSERT(lbl, prop)
`define MSIE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: hw/rtl/msie_pkg.sv
// Package with types, constants and codes of the MIPS subset executor.
`default_nettype none
package msie_pkg;

    localparam int unsigned TEXT_WORDS = 1024;
    localparam int unsigned DATA_BYTES = 16384;
    localparam logic [31:0] TEXT_BASE  = 32'd4194304;
    localparam logic [31:0] DATA_BASE  = 32'd268435456;

    localparam int TEXT_AW = (TEXT_WORDS > 1) ? $clog2(TEXT_WORDS) : 1;
    localparam int DATA_AW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
    localparam int PS_W    = $clog2(TEXT_WORDS + 1);

    // Item modes.
    localparam logic [1:0] MODE_LOAD_INSTR = 2'd0;
    localparam logic [1:0] MODE_LOAD_DATA  = 2'd1;
    localparam logic [1:0] MODE_STEP       = 2'd2;
    localparam logic [1:0] MODE_READ_REG   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PROGRAM_WORDS = 2'd0;
    localparam logic [1:0] CFG_LIMIT_ENABLE  = 2'd1;
    localparam logic [1:0] CFG_STEP_LIMIT    = 2'd2;

    // Opcodes.
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTIU = 6'h0b;
    localparam logic [5:0] OP_ANDI  = 6'h0c;
    localparam logic [5:0] OP_ORI   = 6'h0d;
    localparam logic [5:0] OP_LUI   = 6'h0f;
    localparam logic [5:0] OP_LB    = 6'h20;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SB    = 6'h28;
    localparam logic [5:0] OP_SW    = 6'h2b;

    // Function codes.
    localparam logic [5:0] FN_SLL  = 6'd0;
    localparam logic [5:0] FN_SRL  = 6'd2;
    localparam logic [5:0] FN_JR   = 6'd8;
    localparam logic [5:0] FN_ADDU = 6'd33;
    localparam logic [5:0] FN_SUBU = 6'd35;
    localparam logic [5:0] FN_AND  = 6'd36;
    localparam logic [5:0] FN_OR   = 6'd37;
    localparam logic [5:0] FN_NOR  = 6'd39;
    localparam logic [5:0] FN_SLTU = 6'd43;

    localparam logic [4:0] REG_RA = 5'd31;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] address;
        logic [31:0] value;
    } in_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        done_res;
        logic [31:0] read_value;
    } out_t;

    typedef enum logic [1:0] {
        MK_NONE,
        MK_LOAD,
        MK_STORE
    } mkind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_IMEM_WR,
        ST_DATA_WR,
        ST_CHECK,
        ST_DECODE,
        ST_EXEC,
        ST_LD_REQ,
        ST_LD_CAP,
        ST_ST_WR,
        ST_COMMIT,
        ST_REG_RD,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic take;
        logic imem_wr;
        logic imem_rd;
        logic rf_rd_ops;
        logic rf_rd_item;
        logic exec;
        logic byte_wr;
        logic byte_rd;
        logic byte_cap;
        logic commit;
        logic out_load;
        logic clear;
    } ctl_cmd_t;

    typedef struct packed {
        logic   done_now;
        mkind_t mem_kind;
        logic   byte_last;
        logic   bytes_done;
        logic   clear_last;
    } ctl_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/msie_datapath.sv
// Datapath: stores, register file, ALU, PC, configuration and result register.
`default_nettype none
module msie_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire msie_pkg::in_t       in_data,
    input  wire logic                cfg_write,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [31:0]         cfg_data,
    input  wire msie_pkg::ctl_cmd_t  cmd,
    output msie_pkg::ctl_stat_t      stat,
    output msie_pkg::out_t           out_data
);

    logic [1:0]  mode_reg;
    logic [31:0] addr_reg;
    logic [31:0] val_reg;

    logic [10:0] pw_reg;
    logic        le_reg;
    logic [31:0] limit_reg;
    logic [31:0] pc_reg;
    logic [31:0] count_reg;

    logic [31:0] imem [msie_pkg::TEXT_WORDS];
    logic [31:0] ir_reg;

    logic [31:0] rf_mem [32];
    logic [31:0] rf_valid_reg;
    logic [31:0] qa_reg;
    logic [31:0] qb_reg;
    logic        va_reg;
    logic        vb_reg;

    logic [7:0]  dmem [msie_pkg::DATA_BYTES];
    logic [7:0]  dq_reg;
    logic        rng_reg;
    logic [31:0] acc_reg;
    logic [2:0]  byte_cnt_reg;
    logic [msie_pkg::DATA_AW-1:0] clr_reg;

    logic [31:0]     ea_reg;
    logic [31:0]     wbv_reg;
    logic            wb_en_reg;
    logic [4:0]      wb_idx_reg;
    logic [31:0]     npc_reg;
    msie_pkg::mkind_t mk_reg;
    logic            word_reg;
    logic            lb_reg;

    msie_pkg::out_t  out_reg;

    // Operand values; a register never written reads as zero.
    logic [31:0] a_val;
    logic [31:0] b_val;
    assign a_val = va_reg ? qa_reg : 32'd0;
    assign b_val = vb_reg ? qb_reg : 32'd0;

    // Done test.
    logic [29:0]             tidx;
    logic [msie_pkg::PS_W-1:0] psize;
    logic                    done_now;
    assign tidx  = 30'((pc_reg - msie_pkg::TEXT_BASE) >> 2);
    assign psize = (32'(pw_reg) > 32'(msie_pkg::TEXT_WORDS))
                 ? msie_pkg::PS_W'(msie_pkg::TEXT_WORDS) : msie_pkg::PS_W'(pw_reg);
    assign done_now = (32'(tidx) >= 32'(psize)) || (le_reg && (count_reg >= limit_reg));

    // Decode and execute.
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [31:0] uimm;
    logic [31:0] simm;
    logic [31:0] pc4;
    logic [31:0] jt;
    logic [31:0] x_next;
    logic [31:0] x_wbv;
    logic        x_wb_en;
    logic [4:0]  x_wb_idx;
    msie_pkg::mkind_t x_mk;
    logic        x_word;
    logic        x_lb;

    assign op   = ir_reg[31:26];
    assign rs   = ir_reg[25:21];
    assign rt   = ir_reg[20:16];
    assign rd   = ir_reg[15:11];
    assign sh   = ir_reg[10:6];
    assign fn   = ir_reg[5:0];
    assign uimm = {16'd0, ir_reg[15:0]};
    assign simm = {{16{ir_reg[15]}}, ir_reg[15:0]};
    assign pc4  = pc_reg + 32'd4;
    assign jt   = {pc4[31:28], ir_reg[25:0], 2'b00};

    always_comb
    begin
        x_next   = pc4;
        x_wbv    = 32'd0;
        x_wb_en  = 1'b0;
        x_wb_idx = rt;
        x_mk     = msie_pkg::MK_NONE;
        x_word   = 1'b0;
        x_lb     = 1'b0;
        if (op == msie_pkg::OP_RTYPE)
        begin
            x_wb_idx = rd;
            x_wb_en  = 1'b1;
            unique case (fn)
                msie_pkg::FN_ADDU: x_wbv = a_val + b_val;
                msie_pkg::FN_SUBU: x_wbv = a_val - b_val;
                msie_pkg::FN_AND:  x_wbv = a_val & b_val;
                msie_pkg::FN_OR:   x_wbv = a_val | b_val;
                msie_pkg::FN_NOR:  x_wbv = ~(a_val | b_val);
                msie_pkg::FN_SLTU: x_wbv = {31'd0, a_val < b_val};
                msie_pkg::FN_SLL:  x_wbv = b_val << sh;
                msie_pkg::FN_SRL:  x_wbv = b_val >> sh;
                msie_pkg::FN_JR:
                begin
                    x_wb_en = 1'b0;
                    x_next  = a_val;
                end
                default: x_wb_en = 1'b0;
            endcase
        end
        else
        begin
            unique case (op)
                msie_pkg::OP_J: x_next = jt;
                msie_pkg::OP_JAL:
                begin
                    x_next   = jt;
                    x_wb_en  = 1'b1;
                    x_wb_idx = msie_pkg::REG_RA;
                    x_wbv    = pc4;
                end
                msie_pkg::OP_ADDIU:
                begin
                    x_wb_en = 1'b1;
                    x_wbv   = a_val + simm;
                end
                msie_pkg::OP_ANDI:
                begin
                    x_wb_en = 1'b1;
                    x_wbv   = a_val & uimm;
                end
                msie_pkg::OP_ORI:
                begin
                    x_wb_en = 1'b1;
                    x_wbv   = a_val | uimm;
                end
                msie_pkg::OP_LUI:
                begin
                    x_wb_en = 1'b1;
                    x_wbv   = {ir_reg[15:0], 16'd0};
                end
                msie_pkg::OP_SLTIU:
                begin
                    x_wb_en = 1'b1;
                    x_wbv   = {31'd0, a_val < simm};
                end
                msie_pkg::OP_BEQ:
                begin
                    if (a_val == b_val)
                        x_next = pc4 + {simm[29:0], 2'b00};
                end
                msie_pkg::OP_BNE:
                begin
                    if (a_val != b_val)
                        x_next = pc4 + {simm[29:0], 2'b00};
                end
                msie_pkg::OP_LW:
                begin
                    x_wb_en = 1'b1;
                    x_mk    = msie_pkg::MK_LOAD;
                    x_word  = 1'b1;
                end
                msie_pkg::OP_LB:
                begin
                    x_wb_en = 1'b1;
                    x_mk    = msie_pkg::MK_LOAD;
                    x_lb    = 1'b1;
                end
                msie_pkg::OP_SW:
                begin
                    x_mk   = msie_pkg::MK_STORE;
                    x_word = 1'b1;
                end
                msie_pkg::OP_SB: x_mk = msie_pkg::MK_STORE;
                default: x_next = pc4;
            endcase
        end
    end

    // Byte sequencing for data loads, loads and stores.
    logic        n4;
    logic [31:0] bbase;
    logic [31:0] boff;
    logic        binr;
    logic [31:0] bsrc;
    logic [1:0]  bsel;
    logic [7:0]  wbyte;
    logic [msie_pkg::DATA_AW-1:0] bidx;

    assign n4    = (mode_reg == msie_pkg::MODE_LOAD_DATA) || word_reg;
    assign bbase = (mode_reg == msie_pkg::MODE_LOAD_DATA) ? addr_reg : ea_reg;
    assign boff  = bbase + {30'd0, byte_cnt_reg[1:0]} - msie_pkg::DATA_BASE;
    assign binr  = boff < 32'(msie_pkg::DATA_BYTES);
    assign bidx  = boff[msie_pkg::DATA_AW-1:0];
    assign bsrc  = (mode_reg == msie_pkg::MODE_LOAD_DATA) ? val_reg : b_val;
    // A single-byte store takes the low byte, which is the last byte of a word.
    assign bsel  = n4 ? byte_cnt_reg[1:0] : 2'd3;

    always_comb
    begin
        unique case (bsel)
            2'd0:    wbyte = bsrc[31:24];
            2'd1:    wbyte = bsrc[23:16];
            2'd2:    wbyte = bsrc[15:8];
            default: wbyte = bsrc[7:0];
        endcase
    end

    // Load result and register write port.
    logic [31:0] ldv;
    logic [31:0] rf_wdata;
    logic        rf_we;
    assign ldv      = lb_reg ? {{24{acc_reg[7]}}, acc_reg[7:0]} : acc_reg;
    assign rf_wdata = (mk_reg == msie_pkg::MK_LOAD) ? ldv : wbv_reg;
    assign rf_we    = cmd.commit && wb_en_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg       <= '0;
            le_reg       <= 1'b0;
            limit_reg    <= '0;
            pc_reg       <= msie_pkg::TEXT_BASE;
            count_reg    <= '0;
            rf_valid_reg <= '0;
            byte_cnt_reg <= '0;
            clr_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    msie_pkg::CFG_PROGRAM_WORDS: pw_reg    <= cfg_data[10:0];
                    msie_pkg::CFG_LIMIT_ENABLE:  le_reg    <= cfg_data[0];
                    msie_pkg::CFG_STEP_LIMIT:    limit_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.clear)
                clr_reg <= clr_reg + msie_pkg::DATA_AW'(1);
            if (cmd.take || cmd.exec)
                byte_cnt_reg <= '0;
            else if (cmd.byte_wr || cmd.byte_rd)
                byte_cnt_reg <= byte_cnt_reg + 3'd1;
            if (cmd.commit)
            begin
                pc_reg    <= npc_reg;
                count_reg <= count_reg + 32'd1;
            end
            if (rf_we)
                rf_valid_reg[wb_idx_reg] <= 1'b1;
        end
    end

    // Payload registers and stores.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            mode_reg <= in_data.mode;
            addr_reg <= in_data.address;
            val_reg  <= in_data.value;
        end
        if (cmd.imem_wr && (addr_reg < 32'(msie_pkg::TEXT_WORDS)))
            imem[addr_reg[msie_pkg::TEXT_AW-1:0]] <= val_reg;
        if (cmd.imem_rd)
            ir_reg <= imem[tidx[msie_pkg::TEXT_AW-1:0]];
        if (rf_we)
            rf_mem[wb_idx_reg] <= rf_wdata;
        if (cmd.rf_rd_ops)
        begin
            qa_reg <= rf_mem[rs];
            qb_reg <= rf_mem[rt];
            va_reg <= rf_valid_reg[rs];
            vb_reg <= rf_valid_reg[rt];
        end
        else if (cmd.rf_rd_item)
        begin
            qa_reg <= rf_mem[addr_reg[4:0]];
            va_reg <= rf_valid_reg[addr_reg[4:0]] && (addr_reg[31:5] == 27'd0);
        end
        if (cmd.exec)
        begin
            ea_reg     <= a_val + simm;
            wbv_reg    <= x_wbv;
            wb_en_reg  <= x_wb_en;
            wb_idx_reg <= x_wb_idx;
            npc_reg    <= x_next;
            mk_reg     <= x_mk;
            word_reg   <= x_word;
            lb_reg     <= x_lb;
            acc_reg    <= '0;
        end
        else if (cmd.take)
            word_reg <= 1'b0;
        if (cmd.clear)
            dmem[clr_reg] <= '0;
        else if (cmd.byte_wr && binr)
            dmem[bidx] <= wbyte;
        if (cmd.byte_rd)
        begin
            dq_reg  <= dmem[bidx];
            rng_reg <= binr;
        end
        if (cmd.byte_cap)
            acc_reg <= {acc_reg[23:0], rng_reg ? dq_reg : 8'd0};
        if (cmd.out_load)
        begin
            out_reg.next_pc    <= pc_reg;
            out_reg.done_res   <= done_now;
            out_reg.read_value <= (mode_reg == msie_pkg::MODE_READ_REG) ? a_val : 32'd0;
        end
    end

    assign out_data = out_reg;

    assign stat.done_now   = done_now;
    assign stat.mem_kind   = x_mk;
    assign stat.byte_last  = byte_cnt_reg == (n4 ? 3'd3 : 3'd0);
    assign stat.bytes_done = byte_cnt_reg == (n4 ? 3'd4 : 3'd1);
    assign stat.clear_last = 32'(clr_reg) == 32'(msie_pkg::DATA_BYTES - 1);

endmodule
`default_nettype wire

// File: hw/rtl/msie_ctrl.sv
// Controller state machine of the MIPS subset executor.
`default_nettype none
`include "mips_subset_instruction_executor_unit_macros.svh"
module msie_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           in_mode,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire msie_pkg::ctl_stat_t  stat,
    output msie_pkg::ctl_cmd_t        cmd
);

    msie_pkg::state_t state_reg;
    msie_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msie_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            msie_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                    state_next = msie_pkg::ST_IDLE;
            end
            msie_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    unique case (in_mode)
                        msie_pkg::MODE_LOAD_INSTR: state_next = msie_pkg::ST_IMEM_WR;
                        msie_pkg::MODE_LOAD_DATA:  state_next = msie_pkg::ST_DATA_WR;
                        msie_pkg::MODE_STEP:       state_next = msie_pkg::ST_CHECK;
                        default:                   state_next = msie_pkg::ST_REG_RD;
                    endcase
                end
            end
            msie_pkg::ST_IMEM_WR:
            begin
                cmd.imem_wr = 1'b1;
                state_next  = msie_pkg::ST_RESP;
            end
            msie_pkg::ST_DATA_WR:
            begin
                cmd.byte_wr = 1'b1;
                if (stat.byte_last)
                    state_next = msie_pkg::ST_RESP;
            end
            msie_pkg::ST_CHECK:
            begin
                if (stat.done_now)
                    state_next = msie_pkg::ST_RESP;
                else
                begin
                    cmd.imem_rd = 1'b1;
                    state_next  = msie_pkg::ST_DECODE;
                end
            end
            msie_pkg::ST_DECODE:
            begin
                cmd.rf_rd_ops = 1'b1;
                state_next    = msie_pkg::ST_EXEC;
            end
            msie_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
                unique case (stat.mem_kind)
                    msie_pkg::MK_LOAD:  state_next = msie_pkg::ST_LD_REQ;
                    msie_pkg::MK_STORE: state_next = msie_pkg::ST_ST_WR;
                    default:            state_next = msie_pkg::ST_COMMIT;
                endcase
            end
            msie_pkg::ST_LD_REQ:
            begin
                cmd.byte_rd = 1'b1;
                state_next  = msie_pkg::ST_LD_CAP;
            end
            msie_pkg::ST_LD_CAP:
            begin
                cmd.byte_cap = 1'b1;
                state_next   = stat.bytes_done ? msie_pkg::ST_COMMIT : msie_pkg::ST_LD_REQ;
            end
            msie_pkg::ST_ST_WR:
            begin
                cmd.byte_wr = 1'b1;
                if (stat.byte_last)
                    state_next = msie_pkg::ST_COMMIT;
            end
            msie_pkg::ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = msie_pkg::ST_RESP;
            end
            msie_pkg::ST_REG_RD:
            begin
                cmd.rf_rd_item = 1'b1;
                state_next     = msie_pkg::ST_RESP;
            end
            msie_pkg::ST_RESP:
            begin
                // Wait here only while the previous result beat is still unclaimed.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = msie_pkg::ST_IDLE;
                end
            end
            default: state_next = msie_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    assign in_ready  = state_reg == msie_pkg::ST_IDLE;
    assign out_valid = out_valid_reg;

    `MSIE_ASSERT(a_one_item, (in_valid && in_ready) |=> !in_ready)
    `MSIE_ASSERT(a_load_shows, cmd.out_load |=> out_valid)
    `MSIE_ASSERT(a_clear_ends, (state_reg == msie_pkg::ST_CLEAR && stat.clear_last) |=> in_ready)
    `MSIE_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> (!out_valid && !in_ready))

endmodule
`default_nettype wire

// File: hw/rtl/mips_subset_instruction_executor_unit.sv
// Top level of the MIPS subset executor: controller plus datapath.
//
//  channel | handshake           | payload
//  in      | in_valid / in_ready   | in_data (mode, address, value)
//  out     | out_valid / out_ready | out_data (next_pc, done_res, read_value)
//  cfg     | cfg_write             | cfg_index, cfg_data
//
// Each item runs through its controller states before the next one is taken. A step
// does a registered fetch and registered operand reads and executes; lw, lb, sw and sb
// then move their bytes one at a time through the one byte-wide data memory port.
// After reset the data memory is cleared one byte a cycle, all 16384 bytes, in_ready low.
// A result beat waits in the output register; a new item is taken meanwhile and
// holds in its last cycle until that beat is taken.
`default_nettype none
module mips_subset_instruction_executor_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire msie_pkg::in_t   in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output msie_pkg::out_t       out_data,
    input  wire logic            cfg_write,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [31:0]     cfg_data
);

    msie_pkg::ctl_cmd_t  cmd;
    msie_pkg::ctl_stat_t stat;

    msie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_mode   (in_data.mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    msie_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire
